// ===== sv/crmc_pkg.sv =====
// ----------------------------------------------------------------------------
// crmc_pkg
// Shared constants and types for the capped running-mean normalizer.
// ----------------------------------------------------------------------------
package crmc_pkg;

    // feature vector length and mean memory address width
    localparam int DIM    = 64;
    localparam int DIM_AW = (DIM > 1) ? $clog2(DIM) : 1;

    localparam int MEAN_W = 24;   // Q8.16 mean
    localparam int CNT_W  = 16;   // frame count
    localparam int DEN_W  = CNT_W + 1;
    localparam int NUM_W  = 42;   // signed mean*n + x*256
    localparam int DVD_W  = 41;   // rounded dividend magnitude
    localparam int QUO_W  = 24;   // quotient magnitude, never above 2^23
    localparam int QCNT_W = $clog2(QUO_W);

    // APB register indexes
    localparam logic [1:0] REG_MAX_FRAMES   = 2'd0;
    localparam logic [1:0] REG_START_FRAMES = 2'd1;
    localparam logic [1:0] REG_KEEP_STATS   = 2'd2;

    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] max_frames;
        logic [CNT_W-1:0] start_frames;
        logic             keep_stats;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_START = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

// ===== sv/crmc_ram.sv =====
// ----------------------------------------------------------------------------
// crmc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/crmc_cfg.sv =====
// ----------------------------------------------------------------------------
// crmc_cfg
// APB register file: max_frames, start_frames, keep_stats.
// ----------------------------------------------------------------------------
module crmc_cfg import crmc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MAX_FRAMES:   r_cfg.max_frames   <= pwdata[CNT_W-1:0];
                REG_START_FRAMES: r_cfg.start_frames <= pwdata[CNT_W-1:0];
                REG_KEEP_STATS:   r_cfg.keep_stats   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_FRAMES:   prdata = {16'd0, r_cfg.max_frames};
            REG_START_FRAMES: prdata = {16'd0, r_cfg.start_frames};
            REG_KEEP_STATS:   prdata = {31'd0, r_cfg.keep_stats};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/crmc_div.sv =====
// ----------------------------------------------------------------------------
// crmc_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module crmc_div import crmc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [QUO_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [QCNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_lo;

    logic [DEN_W:0]    w_trial;
    logic              w_qbit;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_lo[QUO_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_den});
        if (w_qbit) begin
            n_rem = DEN_W'(w_trial - {1'b0, r_den});
        end else begin
            n_rem = w_trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == QCNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:QUO_W];
            r_lo  <= i_dividend[QUO_W-1:0];
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[QUO_W-2:0], w_qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_lo;

endmodule

// ===== sv/capped_running_mean_cmn.sv =====
// ----------------------------------------------------------------------------
// capped_running_mean_cmn
// Per-coefficient running mean normalizer with capped averaging weight.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     operation, index, value, last
//   out      output     o_out_valid / i_out_stall   normalized value, index, last
//   cfg      input      APB psel/penable/pwrite     max_frames, start_frames, keep
//
// After acceptance a feed goes through mean read, multiply, divider load,
// 24 divider steps, divider done and write back before the next input is
// taken; an out-of-range index skips the divider. A restart gives no result.
// Reset clears the per-entry valid bits at once; no clearing pass.
// The input stalls from acceptance of a feed until its write-back; a result
// held in the output register stalls the next write-back, and the input with it.
// ----------------------------------------------------------------------------
module capped_running_mean_cmn import crmc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [5:0]         i_coeff_index,
    input  logic signed [15:0] i_coeff_value,
    input  logic               i_last_of_frame,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_normalized_value,
    output logic [5:0]         o_out_index,
    output logic               o_out_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg      w_cfg;
    t_div_stat w_div;
    t_state    r_state;

    logic [DIM-1:0]     r_mean_vld;
    logic [CNT_W-1:0]   r_frame_count;
    logic               r_out_valid;
    logic signed [15:0] r_norm;
    logic [5:0]         r_out_index;
    logic               r_out_last;

    // item being worked on
    logic [5:0]         r_idx;
    logic signed [15:0] r_x;
    logic               r_last;
    logic               r_in_range;
    logic               r_vld;
    logic               r_apply;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_upcoming;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [MEAN_W-1:0] r_mean;

    logic               w_accept;
    logic               w_in_range;
    logic [DIM_AW-1:0]  w_raddr;
    logic [DIM_AW-1:0]  w_addr;
    logic [MEAN_W-1:0]  w_rdata;
    logic               w_load;
    logic [CNT_W-1:0]   w_n;
    logic [CNT_W-1:0]   w_upcoming;

    logic signed [NUM_W-1:0]  w_m;
    logic signed [NUM_W-1:0]  w_n_s;
    logic signed [NUM_W-1:0]  w_num;
    logic [DVD_W-1:0]         w_num_mag;
    logic [DVD_W-1:0]         w_dividend;
    logic [DEN_W-1:0]         w_den;
    logic [QUO_W-1:0]         w_quot;
    logic signed [MEAN_W-1:0] w_mean;

    logic signed [25:0] w_diff;
    logic [25:0]        w_diff_mag;
    logic [17:0]        w_rnd;
    logic signed [18:0] w_res;
    logic signed [15:0] w_out;

    crmc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_in_range = (int'(i_coeff_index) < DIM);
    assign w_raddr    = DIM_AW'(i_coeff_index);
    assign w_addr     = DIM_AW'(r_idx);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        if (w_cfg.max_frames != '0 && r_frame_count > w_cfg.max_frames) begin
            w_n = w_cfg.max_frames;
        end else begin
            w_n = r_frame_count;
        end
        if (r_frame_count != {CNT_W{1'b1}}) begin
            w_upcoming = r_frame_count + 1'b1;
        end else begin
            w_upcoming = r_frame_count;
        end
    end

    crmc_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (DIM)
    ) u_mean_ram (
        .i_clk   (i_clk),
        .i_we    (w_load & r_in_range),
        .i_waddr (w_addr),
        .i_wdata (r_mean),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // mean*n + x*256; an entry never written since clear reads as zero
    always_comb begin
        w_m   = r_vld ? NUM_W'(signed'(w_rdata)) : '0;
        w_n_s = NUM_W'(r_n);
        w_num = w_m * w_n_s + (NUM_W'(r_x) <<< 8);
    end

    // round to nearest, ties away from zero, on the magnitude
    always_comb begin
        w_num_mag  = r_num[NUM_W-1] ? DVD_W'(-r_num) : DVD_W'(r_num);
        w_den      = {1'b0, r_n} + DEN_W'(1);
        w_dividend = w_num_mag + DVD_W'(w_den >> 1);
    end

    crmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_dividend),
        .i_divisor  (w_den),
        .o_stat     (w_div),
        .o_quot     (w_quot)
    );

    assign w_mean = r_num[NUM_W-1] ? -MEAN_W'(w_quot) : MEAN_W'(w_quot);

    // x - mean back to Q8.8, rounded and saturated; x as it is while the mean is not applied
    always_comb begin
        w_diff     = (26'(r_x) <<< 8) - 26'(r_mean);
        w_diff_mag = w_diff[25] ? -w_diff : w_diff;
        w_rnd      = 18'((w_diff_mag + 26'd128) >> 8);
        w_res      = w_diff[25] ? -19'(w_rnd) : 19'(w_rnd);
        if (!r_apply) begin
            w_out = r_x;
        end else if (w_res > 19'sd32767) begin
            w_out = 16'sh7FFF;
        end else if (w_res < -19'sd32768) begin
            w_out = 16'sh8000;
        end else begin
            w_out = 16'(w_res);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mean_vld    <= '0;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_operation == OP_RESTART) begin
                            if (!w_cfg.keep_stats) begin
                                r_mean_vld    <= '0;
                                r_frame_count <= '0;
                            end
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= r_in_range ? S_START : S_DONE;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        if (r_in_range) begin
                            r_mean_vld[w_addr] <= 1'b1;
                        end
                        if (r_last) begin
                            r_frame_count <= r_upcoming;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx      <= i_coeff_index;
            r_x        <= i_coeff_value;
            r_last     <= i_last_of_frame;
            r_in_range <= w_in_range;
            r_vld      <= w_in_range & r_mean_vld[w_raddr];
            r_n        <= w_n;
            r_upcoming <= w_upcoming;
            r_apply    <= (w_upcoming >= w_cfg.start_frames);
        end
        if (r_state == S_READ) begin
            r_num <= w_num;
            if (!r_in_range) begin
                r_mean <= '0;
            end
        end
        if (r_state == S_DIV && w_div.done) begin
            r_mean <= w_mean;
        end
        if (w_load) begin
            r_norm      <= w_out;
            r_out_index <= r_idx;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_normalized_value = r_norm;
    assign o_out_index        = r_out_index;
    assign o_out_last         = r_out_last;

`ifndef SYNTHESIS
    // a new result only ever comes out of the write-back step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside write-back");

    // the divider runs only while the sequencer waits on it
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_state == S_DIV))
        else $error("divider busy outside divide step");

    // the frame count drops only through a restart
    a_count_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_count < $past(r_frame_count)) |->
            $past(w_accept && i_operation == OP_RESTART && !w_cfg.keep_stats))
        else $error("frame count dropped without restart");
`endif

endmodule

// ===== tb/tb_capped_running_mean_cmn.sv =====
// ----------------------------------------------------------------------------
// tb_capped_running_mean_cmn
// Self-checking bench for the capped running-mean normalizer.
//
// A clocked driver feeds coefficient and restart transactions from a queue.
// A clocked monitor predicts each accepted transaction with its own copy of
// the per-index means, the frame count and the registers. It then checks every
// output transaction against the oldest prediction. The run goes through a
// short directed part and then three random phases, each with its own register
// settings and its own idle pattern on the two channels. One long output stall
// makes the block back up and stall its input.
// ----------------------------------------------------------------------------
module tb_capped_running_mean_cmn;
    import crmc_pkg::*;

    localparam int    SETTLE_CYCLES = 64;       // well past one feed in the divider
    localparam int    LONG_HOLD     = 400;
    localparam int    PHASE_ITEMS   = 135;
    localparam int    MAX_REPORTS   = 10;
    // watchdog limit, well beyond the slowest run
    localparam longint CYCLE_LIMIT  = 400_000;

    typedef struct {
        logic               op;
        logic [5:0]         idx;
        logic signed [15:0] value;
        logic               last;
    } t_coeff_item;

    typedef struct {
        logic signed [15:0] value;
        logic [5:0]         idx;
        logic               last;
    } t_norm_result;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic               i_operation     = OP_FEED;
    logic [5:0]         i_coeff_index   = '0;
    logic signed [15:0] i_coeff_value   = '0;
    logic               i_last_of_frame = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic signed [15:0] o_normalized_value;
    logic [5:0]         o_out_index;
    logic               o_out_last;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [3:0]         paddr           = '0;
    logic [31:0]        pwdata          = '0;
    logic [31:0]        prdata;
    logic               pready;

    capped_running_mean_cmn u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_coeff_index      (i_coeff_index),
        .i_coeff_value      (i_coeff_value),
        .i_last_of_frame    (i_last_of_frame),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_normalized_value (o_normalized_value),
        .o_out_index        (o_out_index),
        .o_out_last         (o_out_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic signed [MEAN_W-1:0] mean_m [DIM];
    int unsigned              frames_m;
    int unsigned              max_frames_m;
    int unsigned              start_frames_m;
    logic                     keep_stats_m;

    t_coeff_item  coeff_q [$];
    t_norm_result norm_q  [$];

    int  send_idle_pct = 16;
    int  recv_idle_pct = 82;
    logic in_xfer      = 1'b0;
    logic hold_out     = 1'b0;
    int  hold_at       = 0;

    int items_taken     = 0;
    int feeds_taken     = 0;
    int restarts_taken  = 0;
    int results_checked = 0;
    int clipped_count   = 0;
    int applied_count   = 0;
    int settings_count  = 0;
    int fail_count      = 0;

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_coeff_item mk_item(input logic op, input logic [5:0] idx,
                                            input logic [15:0] value, input logic last);
        t_coeff_item it;
        it.op    = op;
        it.idx   = idx;
        it.value = value;
        it.last  = last;
        return it;
    endfunction

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // fold one accepted transaction into the running means and queue its output
    task automatic fold_coeff(input logic op, input logic [5:0] idx,
                              input logic signed [15:0] x, input logic last);
        longint       n;
        longint       num;
        longint       mean;
        longint       res;
        int unsigned  upcoming;
        t_norm_result r;
        if (op == OP_RESTART) begin
            restarts_taken++;
            if (!keep_stats_m) begin
                foreach (mean_m[i]) mean_m[i] = '0;
                frames_m = 0;
            end
            return;
        end
        feeds_taken++;
        n = frames_m;
        if (max_frames_m != 0 && n > max_frames_m)
            n = max_frames_m;
        upcoming = (frames_m < 65535) ? frames_m + 1 : 65535;
        mean = 0;
        if (int'(idx) < DIM) begin
            num  = longint'(mean_m[idx]) * n + longint'(x) * 256;
            mean = round_div(num, n + 1);
            mean_m[idx] = mean[MEAN_W-1:0];
        end
        if (upcoming >= start_frames_m) begin
            applied_count++;
            res = round_div(longint'(x) * 256 - mean, 256);
            if (res > 32767 || res < -32768)
                clipped_count++;
            if (res > 32767)
                res = 32767;
            if (res < -32768)
                res = -32768;
        end else begin
            res = x;
        end
        if (last)
            frames_m = upcoming;
        r.value = res[15:0];
        r.idx   = idx;
        r.last  = last;
        norm_q.push_back(r);
    endtask

    // input driver: hold the payload until the transaction is taken
    always @(negedge i_clk) begin : drive_in
        t_coeff_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (coeff_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = coeff_q.pop_front();
                i_operation     <= it.op;
                i_coeff_index   <= it.idx;
                i_coeff_value   <= it.value;
                i_last_of_frame <= it.last;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= hold_out || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_norm_result want;
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                items_taken++;
                fold_coeff(i_operation, i_coeff_index, i_coeff_value, i_last_of_frame);
            end
            if (o_out_valid && !i_out_stall) begin
                if (norm_q.size() == 0) begin
                    note_fail($sformatf("unpredicted output value %0d index %0d last %0b",
                                        o_normalized_value, o_out_index, o_out_last));
                end else begin
                    want = norm_q.pop_front();
                    if (o_normalized_value !== want.value || o_out_index !== want.idx ||
                        o_out_last !== want.last)
                        note_fail($sformatf(
                            "result %0d expected value %0d index %0d last %0b, got %0d %0d %0b",
                            results_checked, want.value, want.idx, want.last,
                            o_normalized_value, o_out_index, o_out_last));
                    results_checked++;
                end
            end
        end
    end

    // long output hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_at != 0 && items_taken >= hold_at);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    initial begin
        #(CYCLE_LIMIT * 20);
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(input logic [1:0] ridx, input int unsigned val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (ridx)
            REG_MAX_FRAMES:   max_frames_m   = val & 32'hFFFF;
            REG_START_FRAMES: start_frames_m = val & 32'hFFFF;
            REG_KEEP_STATS:   keep_stats_m   = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned max_f, input int unsigned start_f,
                                  input logic keep);
        write_reg(REG_MAX_FRAMES, max_f);
        write_reg(REG_START_FRAMES, start_f);
        write_reg(REG_KEEP_STATS, keep);
        settings_count++;
    endtask

    // wait out every expected output, then let any restart finish as well
    task automatic wait_idle();
        while (coeff_q.size() != 0 || i_in_valid || norm_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    return 16'($urandom_range(16'hFFFF));
            default: return 16'($urandom_range(4095) - 2048);
        endcase
    endfunction

    // mostly whole frames over one vector slice, with restarts and stray items mixed in
    task automatic queue_random(input int count);
        int added;
        int vec_len;
        int base;
        int r;
        added   = 0;
        vec_len = $urandom_range(8, 2);
        base    = $urandom_range(DIM - vec_len, 0);
        while (added < count) begin
            r = $urandom_range(99);
            if (r < 5) begin
                coeff_q.push_back(mk_item(OP_RESTART, 6'($urandom_range(63)),
                                          16'($urandom_range(16'hFFFF)),
                                          1'($urandom_range(1))));
                added++;
            end else if (r < 15) begin
                coeff_q.push_back(mk_item(OP_FEED, 6'($urandom_range(63)), pick_value(),
                                          1'($urandom_range(1))));
                added++;
            end else begin
                for (int i = 0; i < vec_len; i++)
                    coeff_q.push_back(mk_item(OP_FEED, 6'(base + i), pick_value(),
                                              i == vec_len - 1));
                added += vec_len;
            end
        end
    endtask

    initial begin
        foreach (mean_m[i]) mean_m[i] = '0;
        frames_m       = 0;
        max_frames_m   = 0;
        start_frames_m = 0;
        keep_stats_m   = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through while warming up, then the mean applied; clip at the top
        apply_settings(0, 2, 1'b0);
        coeff_q.push_back(mk_item(OP_FEED, 6'd0, 16'h7FFF, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd5, 16'h8000, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd63, 16'h8000, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd0, 16'h8000, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd5, 16'h7FFF, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd63, 16'h7FFF, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd0, 16'h0001, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd63, 16'hFFFF, 1'b1));
        coeff_q.push_back(mk_item(OP_RESTART, 6'h2A, 16'h5555, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd0, 16'h0100, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd0, 16'hFF00, 1'b1));
        wait_idle();

        // never reach the start count; restart keeps the statistics
        apply_settings(1, 65535, 1'b1);
        coeff_q.push_back(mk_item(OP_FEED, 6'd1, 16'h1234, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd1, 16'hEDCC, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd1, 16'h0400, 1'b1));
        coeff_q.push_back(mk_item(OP_RESTART, 6'h15, 16'hAAAA, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd1, 16'h0000, 1'b1));
        wait_idle();

        // apply the mean from the very first frame, no cap
        apply_settings(65535, 0, 1'b0);
        coeff_q.push_back(mk_item(OP_FEED, 6'd2, 16'h2A5B, 1'b0));
        coeff_q.push_back(mk_item(OP_FEED, 6'd2, 16'hD5A5, 1'b1));
        coeff_q.push_back(mk_item(OP_RESTART, 6'h3F, 16'hFFFF, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd63, 16'h7FFF, 1'b1));
        coeff_q.push_back(mk_item(OP_FEED, 6'd62, 16'h0001, 1'b0));
        wait_idle();

        apply_settings(3, 1, 1'b0);
        queue_random(PHASE_ITEMS);
        wait_idle();

        send_idle_pct = 82;
        recv_idle_pct = 16;
        apply_settings(65535, 3, 1'b1);
        queue_random(PHASE_ITEMS);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_settings($urandom_range(8, 1), $urandom_range(5, 0), 1'b0);
        hold_at = items_taken + 40;
        queue_random(PHASE_ITEMS);
        wait_idle();

        $display("Covered %0d coefficients and %0d restarts under %0d register settings.",
                 feeds_taken, restarts_taken, settings_count);
        $display("Checked %0d outputs: %0d with the mean applied, %0d clipped, %0d mismatches.",
                 results_checked, applied_count, clipped_count, fail_count);
        if (fail_count == 0 && norm_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
